// ===== sv/i2cra_pkg.sv =====
// Shared types, codes and sequence tables for the I2C register access master.
package i2cra_pkg;

  localparam int unsigned GAP_W = 16;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_GAP      = 1'b1;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h60;
  localparam logic [15:0] GAP_RESET = 16'd1000;
  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    SEG_END     = 4'd0,
    SEG_START   = 4'd1,
    SEG_STOP    = 4'd2,
    SEG_GAP     = 4'd3,
    SEG_TX_DEV  = 4'd4,
    SEG_TX_DEVR = 4'd5,
    SEG_TX_REG  = 4'd6,
    SEG_TX_VAL  = 4'd7,
    SEG_RX      = 4'd8
  } seg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       reg_addr;
    logic [7:0]       write_value;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic [1:0]       op_mode;
    logic [3:0]       seg;
    logic [4:0]       phase;
    logic [3:0]       bit_index;
    logic [7:0]       shift_byte;
    logic [7:0]       held_reg_addr;
    logic [7:0]       held_value;
    logic [1:0]       acks_seen;
    logic [GAP_W-1:0] gap_count;
    logic             scl_level;
    logic             sda_level;
  } state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] ack_count;
    logic       request_rejected;
  } result_t;

  // Segment that a given step of the write or read sequence runs.
  function automatic seg_t plan_seg(input logic [1:0] mode, input logic [3:0] idx);
    seg_t s;
    s = SEG_END;
    if (mode == MODE_WRITE) begin
      unique case (idx)
        4'd0: s = SEG_START;
        4'd1: s = SEG_TX_DEV;
        4'd2: s = SEG_TX_REG;
        4'd3: s = SEG_TX_VAL;
        4'd4: s = SEG_STOP;
        4'd5: s = SEG_GAP;
        default: s = SEG_END;
      endcase
    end else if (mode == MODE_READ) begin
      unique case (idx)
        4'd0: s = SEG_START;
        4'd1: s = SEG_TX_DEV;
        4'd2: s = SEG_TX_REG;
        4'd3: s = SEG_STOP;
        4'd4: s = SEG_GAP;
        4'd5: s = SEG_START;
        4'd6: s = SEG_TX_DEVR;
        4'd7: s = SEG_RX;
        4'd8: s = SEG_STOP;
        4'd9: s = SEG_GAP;
        default: s = SEG_END;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== sv/i2cra_step.sv =====
// Next-state and result logic for one tick or request of the I2C master.
module i2cra_step (
  input  i2cra_pkg::state_t                    st,
  input  i2cra_pkg::item_t                     item,
  input  logic [i2cra_pkg::ADDR_W-1:0]         dev_addr,
  input  logic [i2cra_pkg::GAP_W-1:0]          gap_ticks,
  output i2cra_pkg::state_t                    nxt,
  output i2cra_pkg::result_t                   res
);

  i2cra_pkg::seg_t k;
  i2cra_pkg::seg_t k1;
  i2cra_pkg::seg_t k_adv;
  logic [3:0] s1;
  logic [3:0] s_adv;
  logic [4:0] p;
  logic [8:0] prod;
  logic [3:0] q3;
  logic [4:0] mul3;
  logic [4:0] rem5;
  logic [1:0] sub;
  logic [7:0] tx_byte;
  logic [7:0] sh;
  logic busy;
  logic adv;
  logic fin;
  logic rej;
  logic step_phase;

  assign busy = (st.op_mode != i2cra_pkg::MODE_IDLE);
  assign k = i2cra_pkg::plan_seg(st.op_mode, st.seg);
  assign p = st.phase;

  // Phase modulo three through a reciprocal multiply, exact for five-bit phases.
  assign prod = 9'(p) * 9'd11;
  assign q3 = prod[8:5];
  assign mul3 = {q3, 1'b0} + {1'b0, q3};
  assign rem5 = p - mul3;
  assign sub = rem5[1:0];

  always_comb begin
    unique case (k)
      i2cra_pkg::SEG_TX_DEV:  tx_byte = dev_addr;
      i2cra_pkg::SEG_TX_DEVR: tx_byte = dev_addr + 8'd1;
      i2cra_pkg::SEG_TX_REG:  tx_byte = st.held_reg_addr;
      default:                tx_byte = st.held_value;
    endcase
  end

  assign sh = (p == 5'd0) ? tx_byte : st.shift_byte;

  // The next segment, skipping a gap when the gap length is zero.
  assign s1 = st.seg + 4'd1;
  assign k1 = i2cra_pkg::plan_seg(st.op_mode, s1);
  assign s_adv = (k1 == i2cra_pkg::SEG_GAP && gap_ticks == '0) ? (s1 + 4'd1) : s1;
  assign k_adv = i2cra_pkg::plan_seg(st.op_mode, s_adv);

  always_comb begin
    nxt = st;
    adv = 1'b0;
    fin = 1'b0;
    rej = 1'b0;
    step_phase = 1'b0;
    unique case (item.kind)
      i2cra_pkg::KIND_TICK: begin
        if (busy) begin
          step_phase = 1'b1;
          unique case (k)
            i2cra_pkg::SEG_START: begin
              unique case (p)
                5'd0: nxt.sda_level = 1'b1;
                5'd1: nxt.scl_level = 1'b1;
                5'd2: nxt.sda_level = 1'b0;
                default: begin
                  nxt.scl_level = 1'b0;
                  adv = 1'b1;
                end
              endcase
            end
            i2cra_pkg::SEG_STOP: begin
              unique case (p)
                5'd0: nxt.scl_level = 1'b0;
                5'd1: nxt.sda_level = 1'b0;
                5'd2: nxt.scl_level = 1'b1;
                default: begin
                  nxt.sda_level = 1'b1;
                  adv = 1'b1;
                end
              endcase
            end
            i2cra_pkg::SEG_GAP: begin
              nxt.gap_count = st.gap_count + 16'd1;
              if (nxt.gap_count >= gap_ticks) begin
                adv = 1'b1;
              end
            end
            i2cra_pkg::SEG_RX: begin
              if (p == 5'd0) begin
                nxt.sda_level = 1'b1;
                nxt.shift_byte = '0;
                nxt.bit_index = '0;
              end else if (p[0]) begin
                nxt.scl_level = 1'b1;
              end else begin
                nxt.shift_byte = {st.shift_byte[6:0], item.sda_in};
                nxt.scl_level = 1'b0;
                nxt.bit_index = st.bit_index + 4'd1;
                if (p >= 5'd16) begin
                  adv = 1'b1;
                end
              end
            end
            i2cra_pkg::SEG_TX_DEV, i2cra_pkg::SEG_TX_DEVR,
            i2cra_pkg::SEG_TX_REG, i2cra_pkg::SEG_TX_VAL: begin
              nxt.shift_byte = sh;
              if (p == 5'd0) begin
                nxt.bit_index = '0;
              end
              if (p < 5'd24) begin
                unique case (sub)
                  2'd0: nxt.sda_level = |(sh & i2cra_pkg::MSB_MASK);
                  2'd1: nxt.scl_level = 1'b1;
                  default: begin
                    nxt.shift_byte = {sh[6:0], 1'b0};
                    nxt.bit_index = ((p == 5'd0) ? 4'd0 : st.bit_index) + 4'd1;
                    nxt.scl_level = 1'b0;
                  end
                endcase
              end else if (p == 5'd24) begin
                nxt.sda_level = 1'b1;
              end else if (p == 5'd25) begin
                nxt.scl_level = 1'b1;
              end else begin
                if (!item.sda_in) begin
                  nxt.acks_seen = st.acks_seen + 2'd1;
                end
                nxt.scl_level = 1'b0;
                adv = 1'b1;
              end
            end
            default: begin
              step_phase = 1'b0;
              nxt.op_mode = i2cra_pkg::MODE_IDLE;
              nxt.seg = '0;
              nxt.phase = '0;
              fin = 1'b1;
            end
          endcase
        end
      end
      i2cra_pkg::KIND_WRITE, i2cra_pkg::KIND_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          nxt.op_mode = (item.kind == i2cra_pkg::KIND_WRITE) ?
                        i2cra_pkg::MODE_WRITE : i2cra_pkg::MODE_READ;
          nxt.seg = '0;
          nxt.phase = '0;
          nxt.bit_index = '0;
          nxt.gap_count = '0;
          nxt.acks_seen = '0;
          nxt.held_reg_addr = item.reg_addr;
          if (item.kind == i2cra_pkg::KIND_WRITE) begin
            nxt.held_value = item.write_value;
          end
        end
      end
      default: ;
    endcase

    if (adv) begin
      nxt.phase = '0;
      nxt.bit_index = '0;
      nxt.gap_count = '0;
      if (k_adv == i2cra_pkg::SEG_END) begin
        nxt.op_mode = i2cra_pkg::MODE_IDLE;
        nxt.seg = '0;
        fin = 1'b1;
      end else begin
        nxt.seg = s_adv;
      end
    end else if (step_phase) begin
      nxt.phase = p + 5'd1;
    end

    res.scl_out = nxt.scl_level;
    res.sda_out = nxt.sda_level;
    res.busy_res = (nxt.op_mode != i2cra_pkg::MODE_IDLE);
    res.done_res = fin;
    res.read_data = (fin && st.op_mode == i2cra_pkg::MODE_READ) ? nxt.shift_byte : 8'd0;
    res.ack_count = nxt.acks_seen;
    res.request_rejected = rej;
  end

endmodule

// ===== sv/i2c_register_access_master.sv =====
// Top level of the I2C register access master: input register, state and result register.
// A request or tick waits in the input register; its result is loaded into the result
// register as it leaves, which is held back only while a waiting result is stalled.
// Throughput: one item per cycle when not stalled; the sequencer state updates as an
// item leaves the input register, so each item sees the state left by the one before it.
// Reset clears the sequencer to idle with both pins released, sets the device address to
// 0x60 and the gap length to 1000 ticks, and empties both register stages.
module i2c_register_access_master (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        reg_addr,
  input  logic [7:0]                        write_value,
  input  logic                              sda_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              scl_out,
  output logic                              sda_out,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [7:0]                        read_data,
  output logic [1:0]                        ack_count,
  output logic                              request_rejected,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [i2cra_pkg::CFG_DATA_W-1:0]  cfg_data
);

  i2cra_pkg::item_t item;
  logic item_valid;
  i2cra_pkg::state_t state;
  i2cra_pkg::state_t state_next;
  i2cra_pkg::result_t result_next;
  logic [i2cra_pkg::ADDR_W-1:0] dev_addr;
  logic [i2cra_pkg::GAP_W-1:0] gap_ticks;
  logic item_move;

  assign item_move = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !item_move;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= i2cra_pkg::DEV_ADDR_RESET;
      gap_ticks <= i2cra_pkg::GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cra_pkg::CFG_DEV_ADDR: dev_addr <= cfg_data[i2cra_pkg::ADDR_W-1:0];
        i2cra_pkg::CFG_GAP:      gap_ticks <= cfg_data[i2cra_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (item_move) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.kind <= kind;
      item.reg_addr <= reg_addr;
      item.write_value <= write_value;
      item.sda_in <= sda_in;
    end
  end

  i2cra_step u_step (
    .st        (state),
    .item      (item),
    .dev_addr  (dev_addr),
    .gap_ticks (gap_ticks),
    .nxt       (state_next),
    .res       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{op_mode: i2cra_pkg::MODE_IDLE, seg: 4'd0, phase: 5'd0, bit_index: 4'd0,
                 shift_byte: 8'd0, held_reg_addr: 8'd0, held_value: 8'd0, acks_seen: 2'd0,
                 gap_count: '0, scl_level: 1'b1, sda_level: 1'b1};
    end else if (item_move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      scl_out <= result_next.scl_out;
      sda_out <= result_next.sda_out;
      busy_res <= result_next.busy_res;
      done_res <= result_next.done_res;
      read_data <= result_next.read_data;
      ack_count <= result_next.ack_count;
      request_rejected <= result_next.request_rejected;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done shown while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_rejected |-> busy_res)
    else $error("request rejected while idle");

  a_data_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> read_data == 8'd0)
    else $error("read data shown without done");

  a_idle_seg_zero: assert property (@(posedge clk) disable iff (rst)
    state.op_mode == i2cra_pkg::MODE_IDLE |-> state.seg == 4'd0)
    else $error("idle sequencer holds a segment");
`endif

endmodule

// ===== sim/tb_i2c_register_access_master.sv =====
// Self-checking testbench for the I2C register access master.
`timescale 1ns / 100ps

module tb_i2c_register_access_master;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [5:0][3:0] WR_PLAN = {
    i2cra_pkg::SEG_GAP, i2cra_pkg::SEG_STOP, i2cra_pkg::SEG_TX_VAL,
    i2cra_pkg::SEG_TX_REG, i2cra_pkg::SEG_TX_DEV, i2cra_pkg::SEG_START
  };
  localparam logic [9:0][3:0] RD_PLAN = {
    i2cra_pkg::SEG_GAP, i2cra_pkg::SEG_STOP, i2cra_pkg::SEG_RX,
    i2cra_pkg::SEG_TX_DEVR, i2cra_pkg::SEG_START, i2cra_pkg::SEG_GAP,
    i2cra_pkg::SEG_STOP, i2cra_pkg::SEG_TX_REG, i2cra_pkg::SEG_TX_DEV,
    i2cra_pkg::SEG_START
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = i2cra_pkg::KIND_TICK;
  logic [7:0] reg_addr = 8'd0;
  logic [7:0] write_value = 8'd0;
  logic sda_in = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic scl_out;
  logic sda_out;
  logic busy_res;
  logic done_res;
  logic [7:0] read_data;
  logic [1:0] ack_count;
  logic request_rejected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = i2cra_pkg::CFG_DEV_ADDR;
  logic [i2cra_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted sequencer state and configuration.
  i2cra_pkg::mode_t bus_mode;
  logic [3:0] seg_pos;
  logic [4:0] phase;
  logic [7:0] shreg;
  logic [7:0] hold_reg;
  logic [7:0] hold_val;
  logic [1:0] acks;
  logic [i2cra_pkg::GAP_W-1:0] gap_cnt;
  logic scl_lvl;
  logic sda_lvl;
  logic [7:0] dev_addr;
  logic [i2cra_pkg::GAP_W-1:0] gap_len;

  i2cra_pkg::result_t pending_results[$];
  int mismatch_count = 0;
  int items_sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int hold_cmd = 0;
  int hold_left = 0;

  i2c_register_access_master u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .reg_addr(reg_addr),
    .write_value(write_value),
    .sda_in(sda_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scl_out(scl_out),
    .sda_out(sda_out),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .ack_count(ack_count),
    .request_rejected(request_rejected),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic i2cra_pkg::seg_t seg_now();
    if (bus_mode == i2cra_pkg::MODE_WRITE && seg_pos < 4'd6)
      return i2cra_pkg::seg_t'(WR_PLAN[seg_pos]);
    if (bus_mode == i2cra_pkg::MODE_READ && seg_pos < 4'd10)
      return i2cra_pkg::seg_t'(RD_PLAN[seg_pos]);
    return i2cra_pkg::SEG_END;
  endfunction

  function automatic bit next_seg();
    i2cra_pkg::seg_t s;
    seg_pos = seg_pos + 4'd1;
    phase = '0;
    gap_cnt = '0;
    s = seg_now();
    if (s == i2cra_pkg::SEG_GAP && gap_len == '0) begin
      seg_pos = seg_pos + 4'd1;
      s = seg_now();
    end
    if (s == i2cra_pkg::SEG_END) begin
      bus_mode = i2cra_pkg::MODE_IDLE;
      seg_pos = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] tx_source(i2cra_pkg::seg_t s);
    case (s)
      i2cra_pkg::SEG_TX_DEV: return dev_addr;
      i2cra_pkg::SEG_TX_DEVR: return dev_addr + 8'd1;
      i2cra_pkg::SEG_TX_REG: return hold_reg;
      default: return hold_val;
    endcase
  endfunction

  function automatic bit bus_tick(logic sda);
    i2cra_pkg::seg_t s;
    logic [4:0] p;
    bit fin;
    bit moved;
    bit st;
    s = seg_now();
    p = phase;
    fin = 1'b0;
    moved = 1'b0;
    if (s == i2cra_pkg::SEG_START || s == i2cra_pkg::SEG_STOP) begin
      st = (s == i2cra_pkg::SEG_START);
      case (p)
        5'd0: if (st) sda_lvl = 1'b1; else scl_lvl = 1'b0;
        5'd1: if (st) scl_lvl = 1'b1; else sda_lvl = 1'b0;
        5'd2: if (st) sda_lvl = 1'b0; else scl_lvl = 1'b1;
        default: begin
          if (st) scl_lvl = 1'b0; else sda_lvl = 1'b1;
          fin = next_seg();
          moved = 1'b1;
        end
      endcase
    end else if (s == i2cra_pkg::SEG_GAP) begin
      gap_cnt = gap_cnt + 16'd1;
      if (gap_cnt >= gap_len) begin
        fin = next_seg();
        moved = 1'b1;
      end
    end else if (s == i2cra_pkg::SEG_RX) begin
      if (p == 5'd0) begin
        sda_lvl = 1'b1;
        shreg = '0;
      end else if (p[0]) begin
        scl_lvl = 1'b1;
      end else begin
        shreg = {shreg[6:0], sda};
        scl_lvl = 1'b0;
        if (p >= 5'd16) begin
          fin = next_seg();
          moved = 1'b1;
        end
      end
    end else if (s != i2cra_pkg::SEG_END) begin
      if (p == 5'd0) shreg = tx_source(s);
      if (p < 5'd24) begin
        case (p % 5'd3)
          5'd0: sda_lvl = ((shreg & i2cra_pkg::MSB_MASK) != 8'd0);
          5'd1: scl_lvl = 1'b1;
          default: begin
            shreg = {shreg[6:0], 1'b0};
            scl_lvl = 1'b0;
          end
        endcase
      end else if (p == 5'd24) begin
        sda_lvl = 1'b1;
      end else if (p == 5'd25) begin
        scl_lvl = 1'b1;
      end else begin
        if (!sda) acks = acks + 2'd1;
        scl_lvl = 1'b0;
        fin = next_seg();
        moved = 1'b1;
      end
    end else begin
      bus_mode = i2cra_pkg::MODE_IDLE;
      seg_pos = '0;
      phase = '0;
      return 1'b1;
    end
    if (!moved) phase = phase + 5'd1;
    return fin;
  endfunction

  function automatic i2cra_pkg::result_t predict_item(logic [1:0] k, logic [7:0] ra,
                                                      logic [7:0] wv, logic sda);
    i2cra_pkg::result_t r;
    i2cra_pkg::mode_t was;
    bit done;
    bit rej;
    was = bus_mode;
    done = 1'b0;
    rej = 1'b0;
    if (k == i2cra_pkg::KIND_TICK) begin
      if (bus_mode != i2cra_pkg::MODE_IDLE) done = bus_tick(sda);
    end else if (k == i2cra_pkg::KIND_WRITE || k == i2cra_pkg::KIND_READ) begin
      if (bus_mode != i2cra_pkg::MODE_IDLE) begin
        rej = 1'b1;
      end else begin
        if (k == i2cra_pkg::KIND_WRITE) begin
          bus_mode = i2cra_pkg::MODE_WRITE;
          hold_val = wv;
        end else begin
          bus_mode = i2cra_pkg::MODE_READ;
        end
        seg_pos = '0;
        phase = '0;
        gap_cnt = '0;
        acks = '0;
        hold_reg = ra;
      end
    end
    r.scl_out = scl_lvl;
    r.sda_out = sda_lvl;
    r.busy_res = (bus_mode != i2cra_pkg::MODE_IDLE);
    r.done_res = done;
    r.read_data = (done && was == i2cra_pkg::MODE_READ) ? shreg : 8'd0;
    r.ack_count = acks;
    r.request_rejected = rej;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    i2cra_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (scl_out !== want.scl_out) report_mismatch("scl_out", scl_out, want.scl_out);
        if (sda_out !== want.sda_out) report_mismatch("sda_out", sda_out, want.sda_out);
        if (busy_res !== want.busy_res) report_mismatch("busy_res", busy_res, want.busy_res);
        if (done_res !== want.done_res) report_mismatch("done_res", done_res, want.done_res);
        if (read_data !== want.read_data)
          report_mismatch("read_data", read_data, want.read_data);
        if (ack_count !== want.ack_count)
          report_mismatch("ack_count", ack_count, want.ack_count);
        if (request_rejected !== want.request_rejected)
          report_mismatch("request_rejected", request_rejected, want.request_rejected);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cmd != 0) begin
      hold_left = hold_cmd;
      hold_cmd = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_calm || rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 14);
    end
  end

  task automatic send_item(logic [1:0] k, logic [7:0] ra, logic [7:0] wv, logic sda);
    cfg_valid <= 1'b0;
    while (!tx_calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    reg_addr <= ra;
    write_value <= wv;
    sda_in <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_item(k, ra, wv, sda));
    items_sent++;
  endtask

  task automatic send_tick(int low_pct);
    send_item(i2cra_pkg::KIND_TICK, 8'($urandom), 8'($urandom),
              !($urandom_range(99) < low_pct));
  endtask

  task automatic tick_n(int n, int low_pct);
    repeat (n) send_tick(low_pct);
  endtask

  task automatic run_until_idle(int low_pct, int noise_pct);
    while (bus_mode != i2cra_pkg::MODE_IDLE) begin
      if ($urandom_range(99) < noise_pct)
        send_item(2'($urandom_range(3, 1)), 8'($urandom), 8'($urandom), 1'($urandom));
      else
        send_tick(low_pct);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [i2cra_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == i2cra_pkg::CFG_DEV_ADDR) dev_addr = data[7:0];
    else gap_len = data;
  endtask

  task automatic test_reset_state();
    send_tick(50);
    send_item(KIND_SPARE, 8'h33, 8'hCC, 1'b0);
    send_item(i2cra_pkg::KIND_WRITE, 8'hFF, 8'h00, 1'b1);
    tick_n(94, 50);
    send_item(i2cra_pkg::KIND_READ, 8'h12, 8'h34, 1'b0);
    send_item(KIND_SPARE, 8'h00, 8'hFF, 1'b1);
    wait_drain();
    write_cfg(i2cra_pkg::CFG_GAP, 16'd0);
    run_until_idle(50, 0);
    wait_drain();
  endtask

  task automatic test_write_extremes();
    write_cfg(i2cra_pkg::CFG_DEV_ADDR, 16'd0);
    send_item(i2cra_pkg::KIND_WRITE, 8'h00, 8'hFF, 1'b0);
    send_item(i2cra_pkg::KIND_WRITE, 8'h11, 8'h22, 1'b0);
    run_until_idle(100, 0);
    wait_drain();
    write_cfg(i2cra_pkg::CFG_DEV_ADDR, 16'd254);
    send_item(i2cra_pkg::KIND_WRITE, 8'hFF, 8'h00, 1'b1);
    run_until_idle(0, 0);
    wait_drain();
  endtask

  task automatic test_read_extremes();
    write_cfg(i2cra_pkg::CFG_GAP, 16'd1);
    send_item(i2cra_pkg::KIND_READ, 8'h5A, 8'h00, 1'b1);
    tick_n(10, 0);
    send_item(i2cra_pkg::KIND_WRITE, 8'h01, 8'h02, 1'b1);
    run_until_idle(0, 0);
    wait_drain();
    write_cfg(i2cra_pkg::CFG_DEV_ADDR, 16'd0);
    send_item(i2cra_pkg::KIND_READ, 8'hA5, 8'hFF, 1'b0);
    run_until_idle(100, 0);
    wait_drain();
  endtask

  task automatic test_long_gap();
    write_cfg(i2cra_pkg::CFG_GAP, 16'hFFFF);
    write_cfg(i2cra_pkg::CFG_DEV_ADDR, 16'h60);
    send_item(i2cra_pkg::KIND_WRITE, 8'h3C, 8'hC3, 1'b0);
    tick_n(129, 50);
    wait_drain();
    write_cfg(i2cra_pkg::CFG_GAP, 16'd20);
    run_until_idle(50, 0);
    wait_drain();
  endtask

  task automatic test_backpressure();
    write_cfg(i2cra_pkg::CFG_GAP, 16'd3);
    send_item(i2cra_pkg::KIND_READ, 8'h77, 8'h00, 1'b0);
    hold_cmd = 80;
    tick_n(60, 50);
    run_until_idle(50, 0);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int low_pct;
    start = items_sent;
    while (items_sent - start < 1080) begin
      tx_calm = (items_sent - start >= 500 && items_sent - start < 850);
      rx_calm = tx_calm;
      if ($urandom_range(3) == 0) begin
        wait_drain();
        if ($urandom_range(1) == 0)
          write_cfg(i2cra_pkg::CFG_DEV_ADDR, 16'($urandom_range(254)));
        else
          write_cfg(i2cra_pkg::CFG_GAP, ($urandom_range(9) == 0) ? 16'($urandom_range(40, 7))
                                                                 : 16'($urandom_range(6)));
      end
      pick = $urandom_range(99);
      low_pct = ($urandom_range(2) == 0) ? 90 : (($urandom_range(1) == 0) ? 10 : 50);
      if (pick < 8) begin
        repeat ($urandom_range(4, 1))
          send_item(($urandom_range(1) == 0) ? i2cra_pkg::KIND_TICK : KIND_SPARE,
                    8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_item(($urandom_range(1) == 0) ? i2cra_pkg::KIND_WRITE : i2cra_pkg::KIND_READ,
                  8'($urandom), 8'($urandom), 1'($urandom));
        if ($urandom_range(4) == 0) begin
          tick_n($urandom_range(120), low_pct);
          wait_drain();
          write_cfg(i2cra_pkg::CFG_GAP, 16'($urandom_range(6)));
        end
        run_until_idle(low_pct, 3);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    bus_mode = i2cra_pkg::MODE_IDLE;
    seg_pos = '0;
    phase = '0;
    shreg = '0;
    hold_reg = '0;
    hold_val = '0;
    acks = '0;
    gap_cnt = '0;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    dev_addr = i2cra_pkg::DEV_ADDR_RESET;
    gap_len = i2cra_pkg::GAP_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_write_extremes();
    test_read_extremes();
    test_long_gap();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
